// ----- rtl/grm_pkg.sv -----
// Shared constants, types and codes for the gated running median of heart rate.
// No dependencies; every rtl file imports this package.
package grm_pkg;

  // Window depth and derived widths
  localparam int WINDOW  = 9;
  localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int BPM_W   = 8;
  localparam int RATE_W  = 16;
  localparam int CNT_OUT_W = 4;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 1'b1;
  localparam logic [BPM_W-1:0] LOW_LIMIT_RST  = 8'd42;
  localparam logic [BPM_W-1:0] HIGH_LIMIT_RST = 8'd220;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  // Control from the sequencer to the sorted lanes
  typedef struct packed {
    logic clear;
    logic insert;
  } sort_ctl_t;

endpackage

// ----- rtl/grm_sort.sv -----
// Sorted lane array: takes one word a cycle while insert is set and keeps the lanes in ascending order.
// Depends on grm_pkg for the window depth and the control struct.
module grm_sort import grm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  sort_ctl_t        ctl,
  input  logic [BPM_W-1:0] key,
  input  logic [CNT_W-1:0] rank,
  output logic [BPM_W-1:0] rank_val
);

  logic [BPM_W-1:0] lane_r [WINDOW];
  logic [BPM_W-1:0] lane_nxt [WINDOW];
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic [WINDOW-1:0] gt;

  // Mark lanes above the key; unfilled lanes count as above
  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      gt[j] = (CNT_W'(j) >= fill_r) || (lane_r[j] > key);
    end
  end

  // Shift the upper part up by one and drop the key into the gap
  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      if (!gt[j]) begin
        lane_nxt[j] = lane_r[j];
      end else if (j == 0) begin
        lane_nxt[j] = key;
      end else if (!gt[j-1]) begin
        lane_nxt[j] = key;
      end else begin
        lane_nxt[j] = lane_r[j-1];
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.clear) begin
      fill_nxt = '0;
    end else if (ctl.insert) begin
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Lane payload needs no reset
  always_ff @(posedge clk) begin
    if (ctl.insert && !ctl.clear) begin
      for (int j = 0; j < WINDOW; j++) begin
        lane_r[j] <= lane_nxt[j];
      end
    end
  end

  assign rank_val = lane_r[rank[IDX_W-1:0]];

endmodule

// ----- rtl/gated_running_median_rate.sv -----
// Gated running median of heart rate: range gate, ring memory, median by rank walk.
// Depends on grm_pkg and grm_sort.
//
// One word in, one word out. A rate outside the open range between the two limits
// (whole bpm) is rejected; its result, with the unchanged median and count, is loaded
// into the output register from the result state once that register is free. An
// accepted rate is written to the ring memory in the accept cycle; the sequencer then
// reads back every held entry (up to nine with a nine-entry window), one per cycle
// through the single read port of the memory, and inserts each into a sorted lane
// array; once the last entry is in the lanes, the median goes to the result state,
// which loads it into the output register. The input is not ready during the walk
// or the result state, so no new word is taken before the last one is through. The
// input is ready again once the result is registered, while that result still waits
// for the consumer; a result that is still waiting holds the next one, and the input, until it is taken.
module gated_running_median_rate import grm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [RATE_W-1:0]    in_rate_q8,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_accepted,
  output logic [BPM_W-1:0]     out_median_bpm,
  output logic [CNT_OUT_W-1:0] out_held_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BPM_W-1:0]     cfg_wdata
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [BPM_W-1:0] median_r, median_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             acc_r, acc_nxt;
  logic [BPM_W-1:0] lo_r, hi_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_acc_r;
  logic [BPM_W-1:0]     out_med_r;
  logic [CNT_W-1:0]     out_cnt_r;
  logic                 out_load;

  logic [BPM_W-1:0] ring_mem [WINDOW];
  logic [BPM_W-1:0] rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] rd_addr;

  logic             take;
  logic             in_range;
  logic             issue;
  sort_ctl_t        sort_ctl;
  logic [BPM_W-1:0] rank_val;
  logic [31:0]      cnt_ext;

  // Range gate on the Q8.8 rate against whole-bpm limits
  assign in_range = (in_rate_q8 > {lo_r, 8'h00}) && (in_rate_q8 < {hi_r, 8'h00});
  assign in_ready = (state_r == ST_IDLE);
  assign take     = in_valid && in_ready;
  assign mem_we   = take && in_range;
  assign issue    = (state_r == ST_WALK) && (rd_idx_r < count_r);
  assign rd_addr  = rd_idx_r[IDX_W-1:0];
  assign out_load = (state_r == ST_RESULT) && (!out_valid_r || out_ready);

  assign sort_ctl.clear  = take;
  assign sort_ctl.insert = (state_r == ST_WALK) && rd_vld_r;

  grm_sort u_sort (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sort_ctl),
    .key      (rd_data_r),
    .rank     (count_r >> 1),
    .rank_val (rank_val)
  );

  // Ring memory: write in the accept cycle, reads follow in later cycles only
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[slot_r] <= in_rate_q8[RATE_W-1 -: BPM_W];
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    count_nxt  = count_r;
    median_nxt = median_r;
    rd_idx_nxt = rd_idx_r;
    rd_vld_nxt = 1'b0;
    acc_nxt    = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          acc_nxt = in_range;
          if (in_range) begin
            slot_nxt   = (slot_r == IDX_W'(WINDOW - 1)) ? '0 : slot_r + IDX_W'(1);
            count_nxt  = (count_r == CNT_W'(WINDOW)) ? count_r : count_r + CNT_W'(1);
            rd_idx_nxt = '0;
            state_nxt  = ST_WALK;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_WALK: begin
        // Advance the read pointer; finish once the last word is in the lanes
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end else if (!rd_vld_r) begin
          median_nxt = rank_val;
          state_nxt  = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      slot_r   <= '0;
      count_r  <= '0;
      median_r <= '0;
      rd_idx_r <= '0;
      rd_vld_r <= 1'b0;
      acc_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      slot_r   <= slot_nxt;
      count_r  <= count_nxt;
      median_r <= median_nxt;
      rd_idx_r <= rd_idx_nxt;
      rd_vld_r <= rd_vld_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= LOW_LIMIT_RST;
      hi_r <= HIGH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_LIMIT:  lo_r <= cfg_wdata;
        REG_HIGH_LIMIT: hi_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Output register: hold the word until the consumer takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_acc_r <= acc_r;
      out_med_r <= median_r;
      out_cnt_r <= count_r;
    end
  end

  assign cnt_ext        = 32'(out_cnt_r);
  assign out_valid      = out_valid_r;
  assign out_accepted   = out_acc_r;
  assign out_median_bpm = out_med_r;
  assign out_held_count = cnt_ext[CNT_OUT_W-1:0];

endmodule

// ----- rtl/grm_checker.sv -----
// Port-level checker for the gated running median, bound to the top level.
// Depends on grm_pkg for the window depth and field widths.
module grm_checker import grm_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_accepted,
  input logic [BPM_W-1:0]     out_median_bpm,
  input logic [CNT_OUT_W-1:0] out_held_count
);

  logic [BPM_W-1:0]     prev_med_r;
  logic [CNT_OUT_W-1:0] prev_cnt_r;
  logic [CNT_OUT_W-1:0] next_cnt;

  // Track the last delivered word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_med_r <= '0;
      prev_cnt_r <= '0;
    end else if (out_valid && out_ready) begin
      prev_med_r <= out_median_bpm;
      prev_cnt_r <= out_held_count;
    end
  end

  assign next_cnt = (prev_cnt_r == CNT_OUT_W'(WINDOW)) ? prev_cnt_r
                                                       : prev_cnt_r + CNT_OUT_W'(1);

  // A taken input word keeps the input busy for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a word was taken");

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_median_bpm)
                                && $stable(out_held_count) && $stable(out_accepted))
    else $error("result word changed while stalled");

  // A rejected word reports the unchanged state
  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |->
      out_median_bpm == prev_med_r && out_held_count == prev_cnt_r)
    else $error("rejected word changed median or count");

  // An accepted word grows the count up to the window
  a_accept_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted && (WINDOW <= 15) |-> out_held_count == next_cnt)
    else $error("held count did not advance on accepted word");

  // The count never goes past the window
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (WINDOW <= 15) |-> out_held_count <= CNT_OUT_W'(WINDOW))
    else $error("held count beyond window");

endmodule

bind gated_running_median_rate grm_checker u_grm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_accepted   (out_accepted),
  .out_median_bpm (out_median_bpm),
  .out_held_count (out_held_count)
);

// ----- verif/rate_median_sb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the gated running median of heart rate: gate, ring and median predictor.
// Depends on grm_pkg for the window depth, widths and register indexes.
package rate_median_sb_pkg;
  import grm_pkg::*;

  // One expected result word
  typedef struct {
    bit                 accepted;
    bit [BPM_W-1:0]     median_bpm;
    bit [CNT_OUT_W-1:0] held_count;
  } median_word_t;

  class median_scoreboard;
    bit [BPM_W-1:0] low_limit;
    bit [BPM_W-1:0] high_limit;
    bit [BPM_W-1:0] bpm_ring [WINDOW];
    int unsigned    ring_slot;
    int unsigned    ring_held;
    bit [BPM_W-1:0] median_now;
    median_word_t   expected_words [$];
    int unsigned    errors;
    int unsigned    checked;
    int unsigned    stored;
    int unsigned    gated_off;

    function new();
      low_limit  = LOW_LIMIT_RST;
      high_limit = HIGH_LIMIT_RST;
      ring_slot  = 0;
      ring_held  = 0;
      median_now = '0;
      errors     = 0;
      checked    = 0;
      stored     = 0;
      gated_off  = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] index, bit [BPM_W-1:0] value);
      if (index == REG_LOW_LIMIT) low_limit = value;
      else if (index == REG_HIGH_LIMIT) high_limit = value;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    // Pick the held value whose rank range covers held/2 (upper middle on even counts)
    function bit [BPM_W-1:0] window_median();
      int unsigned below;
      int unsigned not_above;
      int unsigned rank;
      rank = ring_held / 2;
      for (int i = 0; i < ring_held; i++) begin
        below = 0;
        not_above = 0;
        for (int j = 0; j < ring_held; j++) begin
          if (bpm_ring[j] < bpm_ring[i]) below++;
          if (bpm_ring[j] <= bpm_ring[i]) not_above++;
        end
        if (below <= rank && rank < not_above) return bpm_ring[i];
      end
      return '0;
    endfunction

    // Gate the rate, update the window and queue the word the block must answer with
    function void note_rate(bit [RATE_W-1:0] rate_q8);
      median_word_t w;
      w.accepted = (rate_q8 > {low_limit, 8'h00}) && (rate_q8 < {high_limit, 8'h00});
      if (w.accepted) begin
        bpm_ring[ring_slot] = rate_q8[RATE_W-1:RATE_W-BPM_W];
        ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
        if (ring_held < WINDOW) ring_held++;
        median_now = window_median();
        stored++;
      end else begin
        gated_off++;
      end
      w.median_bpm = median_now;
      w.held_count = CNT_OUT_W'(ring_held);
      expected_words.push_back(w);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Compare one result word with the oldest expectation
    task check_result(bit accepted, bit [BPM_W-1:0] median_bpm, bit [CNT_OUT_W-1:0] held_count);
      median_word_t w;
      if (expected_words.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        w = expected_words.pop_front();
        checked++;
        if (accepted !== w.accepted)
          report($sformatf("accepted got %0b want %0b", accepted, w.accepted));
        if (median_bpm !== w.median_bpm)
          report($sformatf("median_bpm got %0d want %0d", median_bpm, w.median_bpm));
        if (held_count !== w.held_count)
          report($sformatf("held_count got %0d want %0d", held_count, w.held_count));
      end
    endtask
  endclass

endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level bench for gated_running_median_rate: clock, reset, drivers and phases.
// Depends on grm_pkg, rate_median_sb_pkg and the block under test.
module tb_top;
  import grm_pkg::*;
  import rate_median_sb_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [RATE_W-1:0]    in_rate_q8 = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_accepted;
  logic [BPM_W-1:0]     out_median_bpm;
  logic [CNT_OUT_W-1:0] out_held_count;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LOW_LIMIT;
  logic [BPM_W-1:0]     cfg_wdata = '0;

  median_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_request = 0;
  int limit_settings = 0;

  gated_running_median_rate dut (.*);

  always #5 clk = ~clk;

  // Note accepted input words and check accepted result words
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_rate(in_rate_q8);
      if (out_valid && out_ready) sb.check_result(out_accepted, out_median_bpm, out_held_count);
    end
  end

  // Result side: random stalls, plus a long hold-off when asked for
  initial begin
    int holdoff_left;
    holdoff_left = 0;
    forever begin
      @(posedge clk);
      if (holdoff_left > 0) begin
        out_ready <= 1'b0;
        holdoff_left--;
      end else if (holdoff_request > 0) begin
        holdoff_left = holdoff_request - 1;
        holdoff_request = 0;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one rate word, idling first at random, and hold it until taken
  task send_rate(bit [RATE_W-1:0] rate_q8);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    in_rate_q8 <= rate_q8;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every expected word has come back
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write both limits on consecutive cycles; block is idle here
  task set_limits(bit [BPM_W-1:0] low_bpm, bit [BPM_W-1:0] high_bpm);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOW_LIMIT;
    cfg_wdata <= low_bpm;
    @(posedge clk);
    cfg_index <= REG_HIGH_LIMIT;
    cfg_wdata <= high_bpm;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(REG_LOW_LIMIT, low_bpm);
    sb.set_limit(REG_HIGH_LIMIT, high_bpm);
    limit_settings++;
  endtask

  // Mostly rates inside the current limits, some at the edges, some anywhere
  function bit [RATE_W-1:0] pick_rate();
    int pick;
    bit [BPM_W-1:0] low_bpm;
    bit [BPM_W-1:0] high_bpm;
    low_bpm  = sb.low_limit;
    high_bpm = sb.high_limit;
    pick = $urandom_range(99);
    if (pick < 8) return RATE_W'($urandom);
    if (pick < 16) begin
      case ($urandom_range(5))
        0: return {low_bpm, 8'h00};
        1: return {low_bpm, 8'h01};
        2: return {high_bpm, 8'h00} - 1'b1;
        3: return {high_bpm, 8'h00};
        4: return '0;
        default: return '1;
      endcase
    end
    // clustered values give duplicates in the window
    if (pick < 35 && low_bpm < high_bpm)
      return {BPM_W'(low_bpm + $urandom_range(3) % (high_bpm - low_bpm)),
              BPM_W'($urandom_range(255))};
    return {BPM_W'($urandom_range(low_bpm, high_bpm)), BPM_W'($urandom_range(255))};
  endfunction

  // Stimulus
  initial begin
    bit [RATE_W-1:0] directed [$];
    bit [BPM_W-1:0]  low_tab  [9];
    bit [BPM_W-1:0]  high_tab [9];
    int              phase_items;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset limits: edges, rejects, fill and wrap
    directed = '{16'h0000, 16'hFFFF, 16'h2A00, 16'h2A01, 16'hDBFF, 16'hDC00,
                 16'h6400, 16'h32FF, 16'h9680, 16'h6400, 16'h5000, 16'hC800,
                 16'h3C00, 16'h7800, 16'h5A00, 16'h4600, 16'h8200, 16'h2AFF,
                 16'hDC01, 16'h6401};
    foreach (directed[i]) send_rate(directed[i]);
    drain();
    repeat (16) @(posedge clk);

    // Limit settings: reset, widest, narrowest, crossed, equal, bottom and top edges, then two random
    low_tab  = '{8'd42,  8'd0,   8'd60, 8'd255, 8'd100, 8'd0, 8'd254, 8'd0, 8'd0};
    high_tab = '{8'd220, 8'd255, 8'd61, 8'd0,   8'd100, 8'd1, 8'd255, 8'd0, 8'd0};
    for (int p = 0; p < 2; p++) begin
      low_tab[7 + p]  = BPM_W'($urandom_range(200));
      high_tab[7 + p] = BPM_W'(low_tab[7 + p] + $urandom_range(1, 55));
    end

    for (int phase = 0; phase < 9; phase++) begin
      set_limits(low_tab[phase], high_tab[phase]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      phase_items = (low_tab[phase] >= high_tab[phase]) ? 60 : 200;
      for (int i = 0; i < phase_items; i++) begin
        // long receiver hold-off while words keep coming in
        if (phase == 0 && i == 100) holdoff_request = 200;
        // sender pause until the block has answered everything
        if (phase == 5 && i == 100) drain();
        send_rate(pick_rate());
      end
      drain();
      repeat (16) @(posedge clk);
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d rate words (%0d stored, %0d gated off) across %0d limit settings,",
             sb.checked, sb.stored, sb.gated_off, limit_settings);
    $display("with idle, stalled, mixed and back-pressured handshakes; %0d mismatches.",
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/grm_pkg.sv
rtl/grm_sort.sv
rtl/gated_running_median_rate.sv
rtl/grm_checker.sv
verif/rate_median_sb_pkg.sv
verif/tb_top.sv
